@@ hdl/susu_pkg.sv @@
// ----------------------------------------------------------------------------
// susu_pkg: shared types and constants of the sorted unique set unit
// Holds the capacity, the command and status codes, and the beat formats of
// the input and result channels.
// ----------------------------------------------------------------------------
package susu_pkg;

    // Set capacity and the widths that follow from it
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;

    // Commands
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_ELEMENT   = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    // Input beat
    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] element;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_out_beat;

    // Flags from the shared comparator
    typedef struct packed {
        logic eq;   // stored == operand
        logic gt;   // stored > operand, signed order
    } t_cmp_flags;

endpackage

@@ hdl/susu_ram.sv @@
// ----------------------------------------------------------------------------
// susu_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module susu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/susu_cmp.sv @@
// ----------------------------------------------------------------------------
// susu_cmp: shared signed comparator
// Compares one stored entry with the operand of the current command.
// ----------------------------------------------------------------------------
module susu_cmp import susu_pkg::*; (
    input  logic signed [VALUE_W-1:0] i_stored,
    input  logic signed [VALUE_W-1:0] i_operand,
    output t_cmp_flags                o_flags
);

    // One equality and one signed magnitude compare
    assign o_flags.eq = (i_stored == i_operand);
    assign o_flags.gt = (i_stored > i_operand);

endmodule

@@ hdl/sorted_unique_set_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_unit: ascending set of distinct signed 32-bit values
// Insert, delete and dump over a RAM-held sorted list, one entry at a time.
// ----------------------------------------------------------------------------
// The set lives in a single-port-read RAM of CAPACITY words kept in ascending
// order in entries 0 .. count-1. Every command walks the stored entries from
// the bottom, one entry at a time: RAM read, then compare in the shared
// comparator and write back. A delete, or an insert that goes in, walks all
// stored entries before its result beat. An insert that meets an equal entry,
// or a larger entry while the set is full, stops there. A dump walks all
// stored entries, and an empty dump walks none. Any result beat, and so the
// walk, also waits while the output register still holds a stalled beat. The
// input side is ready again the cycle after the command ends. Insert shifts
// larger entries up by one in the same pass, delete pulls the entries above
// the match down by one. The input side stalls while a command is in progress;
// a finished result sits in the output register and does not hold off the next
// command. A command code of 3 is taken and dropped without a result. The RAM
// needs no clearing after reset: only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_unique_set_unit import susu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    // Registers
    t_state                    r_state,     n_state;
    logic [1:0]                r_cmd,       n_cmd;
    logic signed [VALUE_W-1:0] r_val,       n_val;
    logic signed [VALUE_W-1:0] r_carry,     n_carry;
    logic [CNT_W-1:0]          r_idx,       n_idx;
    logic [CNT_W-1:0]          r_cnt,       n_cnt;
    logic                      r_shift,     n_shift;
    logic                      r_out_valid, n_out_valid;
    t_out_beat                 r_out,       n_out;

    // RAM and comparator wiring
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] stored;
    t_cmp_flags                flags;

    logic in_beat;
    logic slot_free;
    logic full;

    assign in_beat   = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign full      = (r_cnt == CNT_W'(CAPACITY));
    assign stored    = $signed(rd_data);

    susu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    susu_cmp u_cmp (
        .i_stored  (stored),
        .i_operand (r_val),
        .o_flags   (flags)
    );

    // Sequencer next state
    always_comb begin
        logic [CNT_W-1:0] idx_inc;
        logic [CNT_W-1:0] idx_dec;
        idx_inc     = r_idx + CNT_W'(1);
        idx_dec     = r_idx - CNT_W'(1);
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_carry     = r_carry;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_idx[ADDR_W-1:0];
        wr_data     = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_cmd   = i_in_data.cmd;
                    n_val   = i_in_data.value;
                    n_idx   = '0;
                    n_shift = 1'b0;
                    case (i_in_data.cmd)
                        CMD_INSERT, CMD_DELETE, CMD_DUMP: n_state = S_RD;
                        default:                          n_state = S_IDLE;
                    endcase
                end
            end

            // read address is r_idx; data lands for the compare step
            S_RD: begin
                if (r_idx == r_cnt) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CMP;
                end
            end

            S_CMP: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (r_shift) begin
                            // ripple the carried entry up one place
                            wr_en   = 1'b1;
                            wr_data = r_carry;
                            n_carry = stored;
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end else if (flags.eq || (flags.gt && full)) begin
                            if (slot_free) begin
                                n_out_valid    = 1'b1;
                                n_out.status   = flags.eq ? ST_DUPLICATE : ST_FULL;
                                n_out.element  = r_val;
                                n_out.count    = COUNT_W'(r_cnt);
                                n_out.last     = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end else if (flags.gt) begin
                            // insertion point found
                            wr_en   = 1'b1;
                            wr_data = r_val;
                            n_carry = stored;
                            n_shift = 1'b1;
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_shift) begin
                            // pull this entry down over the gap
                            wr_en   = 1'b1;
                            wr_addr = idx_dec[ADDR_W-1:0];
                            wr_data = stored;
                        end else if (flags.eq) begin
                            n_shift = 1'b1;
                        end
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end
                    CMD_DUMP: begin
                        if (slot_free) begin
                            n_out_valid   = 1'b1;
                            n_out.status  = ST_ELEMENT;
                            n_out.element = stored;
                            n_out.count   = COUNT_W'(r_cnt);
                            n_out.last    = (idx_inc == r_cnt);
                            n_idx         = idx_inc;
                            n_state       = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // end of walk: final insert write and any closing result
            S_FIN: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (slot_free) begin
                            n_out_valid   = 1'b1;
                            n_out.element = r_val;
                            n_out.last    = 1'b1;
                            n_state       = S_IDLE;
                            if (full && !r_shift) begin
                                n_out.status = ST_FULL;
                                n_out.count  = COUNT_W'(r_cnt);
                            end else begin
                                wr_en        = 1'b1;
                                wr_data      = r_shift ? r_carry : r_val;
                                n_cnt        = r_cnt + CNT_W'(1);
                                n_out.status = ST_INSERTED;
                                n_out.count  = COUNT_W'(n_cnt);
                            end
                        end
                    end
                    CMD_DELETE: begin
                        if (slot_free) begin
                            n_out_valid   = 1'b1;
                            n_out.element = r_val;
                            n_out.last    = 1'b1;
                            n_state       = S_IDLE;
                            if (r_shift) begin
                                n_cnt        = r_cnt - CNT_W'(1);
                                n_out.status = ST_DELETED;
                            end else begin
                                n_out.status = ST_NOTFOUND;
                            end
                            n_out.count = COUNT_W'(n_cnt);
                        end
                    end
                    CMD_DUMP: begin
                        if (r_cnt != '0) begin
                            n_state = S_IDLE;
                        end else if (slot_free) begin
                            n_out_valid   = 1'b1;
                            n_out.status  = ST_EMPTY;
                            n_out.element = r_val;
                            n_out.count   = '0;
                            n_out.last    = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_shift     <= 1'b0;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_shift     <= n_shift;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
        r_val   <= n_val;
        r_carry <= n_carry;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // count stays within capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // count only moves at the closing step of a command
    a_cnt_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> ($past(r_state) == S_FIN))
        else $error("entry count changed outside closing step");

    // no RAM write while idle
    a_idle_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("RAM write while idle");

    // a dump never modifies the set
    a_dump_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (r_cmd == CMD_DUMP)) |-> !wr_en)
        else $error("RAM write during dump");
`endif

endmodule

@@ tb/tb_sorted_unique_set_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_unique_set_unit: self-checking bench for the sorted unique set
// Drives insert, delete, dump and unused command beats, holds a copy of the
// set to work out every result beat, and compares each result beat field by
// field in arrival order. Both channels idle in random bursts. Directed beats
// come first, then random episodes that fill the set to capacity, drain it
// and mix commands in between.
// ----------------------------------------------------------------------------
module tb_sorted_unique_set_unit;
    import susu_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int ITEM_GOAL   = 350;
    localparam int QUIET_TAIL  = 40;
    localparam int CYCLE_LIMIT = 4000000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    // Command beats still to send, and result beats still to arrive
    t_in_beat  cmd_backlog[$];
    t_out_beat due_set_results[$];

    // Set contents as the bench tracks them at beat acceptance
    logic signed [VALUE_W-1:0] set_contents[CAPACITY];
    int set_size = 0;

    // Membership seen by the stimulus builder, order not kept
    logic signed [VALUE_W-1:0] gen_members[$];
    int cmds_made = 0;

    int        mismatches     = 0;
    int        beats_checked  = 0;
    int        cmds_taken     = 0;
    int        full_refusals  = 0;
    int        empty_dumps    = 0;
    int        send_gap       = 0;
    int        stall_gap      = 0;
    logic      quiet_tail     = 1'b0;
    logic [31:0] cycle_count  = '0;
    t_out_beat want;
    logic      may_idle;

    // Idling is off near the end and in one calm stretch out of every four
    assign may_idle = !quiet_tail && (cycle_count[9:8] != 2'b11);

    sorted_unique_set_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch at result beat %0d: %s", $time, beats_checked, what);
    endtask

    // Apply one accepted command to the tracked set, queue its result beats
    task automatic apply_set_command(input t_in_beat beat);
        logic signed [VALUE_W-1:0] v;
        t_out_beat r;
        int pos;
        int k;
        v         = beat.value;
        r.element = v;
        r.last    = 1'b1;
        case (beat.cmd)
            CMD_INSERT: begin
                pos = 0;
                while (pos < set_size && set_contents[pos] < v) pos++;
                if (pos < set_size && set_contents[pos] == v) begin
                    r.status = ST_DUPLICATE;
                end else if (set_size >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_refusals++;
                end else begin
                    for (k = set_size; k > pos; k--) set_contents[k] = set_contents[k-1];
                    set_contents[pos] = v;
                    set_size++;
                    r.status = ST_INSERTED;
                end
                r.count = set_size[COUNT_W-1:0];
                due_set_results.push_back(r);
            end
            CMD_DELETE: begin
                pos = 0;
                while (pos < set_size && set_contents[pos] != v) pos++;
                if (pos >= set_size) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (k = pos; k + 1 < set_size; k++) set_contents[k] = set_contents[k+1];
                    set_size--;
                    r.status = ST_DELETED;
                end
                r.count = set_size[COUNT_W-1:0];
                due_set_results.push_back(r);
            end
            CMD_DUMP: begin
                r.count = set_size[COUNT_W-1:0];
                if (set_size == 0) begin
                    r.status = ST_EMPTY;
                    empty_dumps++;
                    due_set_results.push_back(r);
                end else begin
                    for (k = 0; k < set_size; k++) begin
                        r.status  = ST_ELEMENT;
                        r.element = set_contents[k];
                        r.last    = (k == set_size - 1);
                        due_set_results.push_back(r);
                    end
                end
            end
            default: ;  // unused code: no result, set unchanged
        endcase
    endtask

    function automatic int member_index(input logic signed [VALUE_W-1:0] v);
        int k;
        for (k = 0; k < gen_members.size(); k++) begin
            if (gen_members[k] == v) return k;
        end
        return -1;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_member();
        return gen_members[$urandom_range(0, gen_members.size() - 1)];
    endfunction

    // Mix of small values (collisions), stored values, extremes and wide values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        int s;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            s = $urandom_range(0, 40);
            return s - 20;
        end
        if (sel < 5 && gen_members.size() != 0) return random_member();
        if (sel < 6) begin
            case ($urandom_range(0, 5))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_MIN + 1;
                3:       return VAL_MAX - 1;
                4:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_command(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] v);
        t_in_beat b;
        int at;
        b.cmd   = cmd;
        b.value = v;
        cmd_backlog.push_back(b);
        at = member_index(v);
        if (cmd == CMD_INSERT && at < 0 && gen_members.size() < CAPACITY) begin
            gen_members.push_back(v);
        end
        if (cmd == CMD_DELETE && at >= 0) gen_members.delete(at);
        if (cmd != CMD_UNUSED) cmds_made++;
    endtask

    task automatic build_stimulus();
        logic signed [VALUE_W-1:0] v;
        int episode;
        int n;
        int k;
        int sel;
        // directed: empty set, extremes, duplicates, misses, unused code
        queue_command(CMD_DUMP, 77);
        queue_command(CMD_DELETE, 5);
        queue_command(CMD_UNUSED, VAL_MAX);
        queue_command(CMD_INSERT, 0);
        queue_command(CMD_INSERT, VAL_MAX);
        queue_command(CMD_INSERT, VAL_MIN);
        queue_command(CMD_INSERT, -1);
        queue_command(CMD_INSERT, 1);
        queue_command(CMD_INSERT, 0);
        queue_command(CMD_INSERT, VAL_MAX);
        queue_command(CMD_DELETE, 2);
        queue_command(CMD_DUMP, 0);
        queue_command(CMD_DELETE, VAL_MIN);
        queue_command(CMD_DELETE, VAL_MAX);
        queue_command(CMD_DELETE, 0);
        queue_command(CMD_DELETE, 0);
        queue_command(CMD_DUMP, VAL_MIN);
        queue_command(CMD_DELETE, -1);
        queue_command(CMD_DELETE, 1);
        queue_command(CMD_DUMP, -1);
        queue_command(CMD_UNUSED, 0);

        // random episodes: mixed, fill to capacity, mixed, drain to empty
        episode = 0;
        while (cmds_made < ITEM_GOAL) begin
            case (episode % 4)
                1: begin
                    while (gen_members.size() < CAPACITY) begin
                        if ($urandom_range(0, 3) == 0) queue_command(CMD_INSERT, pick_value());
                        else queue_command(CMD_INSERT, $urandom);
                    end
                    queue_command(CMD_INSERT, random_member());  // duplicate while full
                    queue_command(CMD_INSERT, $urandom);         // refused while full
                    queue_command(CMD_DUMP, $urandom);
                    v = random_member();
                    queue_command(CMD_DELETE, v);
                    queue_command(CMD_INSERT, v);
                    queue_command(CMD_INSERT, ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX);
                end
                3: begin
                    while (gen_members.size() != 0) begin
                        sel = $urandom_range(0, 99);
                        if (sel < 85) queue_command(CMD_DELETE, random_member());
                        else if (sel < 95) queue_command(CMD_DELETE, pick_value());
                        else queue_command(CMD_DUMP, $urandom);
                    end
                    queue_command(CMD_DUMP, $urandom);
                    queue_command(CMD_DELETE, pick_value());
                end
                default: begin
                    n = $urandom_range(12, 30);
                    for (k = 0; k < n; k++) begin
                        sel = $urandom_range(0, 99);
                        if (sel < 45) begin
                            queue_command(CMD_INSERT, pick_value());
                        end else if (sel < 80) begin
                            if (gen_members.size() != 0 && $urandom_range(0, 2) != 0) begin
                                queue_command(CMD_DELETE, random_member());
                            end else begin
                                queue_command(CMD_DELETE, pick_value());
                            end
                        end else if (sel < 94) begin
                            queue_command(CMD_DUMP, $urandom);
                        end else begin
                            queue_command(CMD_UNUSED, $urandom);
                        end
                    end
                end
            endcase
            episode++;
        end
    endtask

    // Command driver: holds a beat while stalled, idles in bursts between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_set_command(i_in_data);
                cmds_taken++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (may_idle && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 11);
                    i_in_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    i_in_data  <= cmd_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            quiet_tail <= (cmd_backlog.size() < QUIET_TAIL);
        end
    end

    // Result monitor: checks each accepted beat, stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_checked++;
                if (due_set_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, status %0d element %0d",
                                              o_out_data.status, o_out_data.element));
                end else begin
                    want = due_set_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_out_data.status, want.status));
                    if (o_out_data.element !== want.element)
                        report_mismatch($sformatf("element %0d, want %0d",
                                                  o_out_data.element, want.element));
                    if (o_out_data.count !== want.count)
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  o_out_data.count, want.count));
                    if (o_out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  o_out_data.last, want.last));
                end
            end
            if (stall_gap > 0) begin
                stall_gap = stall_gap - 1;
                i_out_stall <= 1'b1;
            end else if (may_idle && $urandom_range(0, 4) == 0) begin
                stall_gap = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats outstanding",
                     cycle_count, due_set_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (due_set_results.size() != 0) @(posedge i_clk);
        // a trailing unused command or a late extra beat would show up here
        repeat (2 * CAPACITY + 16) @(posedge i_clk);

        $display("%0d commands taken, %0d result beats checked, %0d mismatches",
                 cmds_taken, beats_checked, mismatches);
        $display("inserts refused at capacity: %0d, dumps of an empty set: %0d",
                 full_refusals, empty_dumps);
        if (mismatches == 0 && due_set_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
